FILE: sv/iqlc_pkg.sv
package iqlc_pkg;

    localparam int ADC_W   = 12;
    localparam int CODE_W  = 10;
    localparam int PWR_W   = 26;
    localparam int ITER_W  = 8;
    localparam int ANGLE_W = 6;
    localparam int DEG_W   = 9;
    localparam int SAMP_W  = 13;
    localparam int TRIG_W  = 17;
    localparam int NUM_W   = 30;
    localparam int DELTA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_DAC_CENTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERS       = 2'd2;

    localparam logic [CODE_W-1:0] RST_DAC_CENTER  = 10'd512;
    localparam logic [ADC_W-1:0]  RST_COMMON_MODE = 12'd1861;
    localparam logic [ITER_W-1:0] RST_ITERS       = 8'd50;
    localparam logic [PWR_W-1:0]  POWER_INIT      = 26'd33554432;
    localparam logic [CODE_W-1:0] CODE_MAX        = 10'd1023;

    // Operation decided for a beat when it is accepted.
    localparam logic [2:0] OP_IDLE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_ADJUST  = 3'd2;
    localparam logic [2:0] OP_MEASURE = 3'd3;
    localparam logic [2:0] OP_LAST    = 3'd4;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_STARTED  = 3'd1;
    localparam logic [2:0] PH_ADJUSTED = 3'd2;
    localparam logic [2:0] PH_MEASURED = 3'd3;
    localparam logic [2:0] PH_FINISHED = 3'd4;

    // Division by 100 * 32768 = 25 * 2^17: shift by 17, then divide by 25
    // with a reciprocal multiply that is exact for 11-bit values.
    localparam int DIV_SHIFT = 17;
    localparam int RECIP_SH  = 16;
    localparam logic [11:0] RECIP_25 = 12'd2622;

    typedef struct packed {
        logic              action;
        logic [ADC_W-1:0]  adc_q;
        logic [ADC_W-1:0]  adc_i;
    } t_in_beat;

    typedef struct packed {
        logic [CODE_W-1:0] dac_q_pos;
        logic [CODE_W-1:0] dac_q_neg;
        logic [CODE_W-1:0] dac_i_pos;
        logic [CODE_W-1:0] dac_i_neg;
        logic [2:0]        phase;
        logic [PWR_W-1:0]  best_power;
    } t_out_beat;

    // sin(d) * 32768 rounded, d = 0..90 degrees.
    function automatic logic [15:0] sin_q15(input logic [6:0] d);
        logic [15:0] v;
        case (d)
            7'd0: v = 16'd0;         7'd1: v = 16'd572;       7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;      7'd4: v = 16'd2286;      7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;      7'd7: v = 16'd3993;      7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;      7'd10: v = 16'd5690;     7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;     7'd13: v = 16'd7371;     7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;     7'd16: v = 16'd9032;     7'd17: v = 16'd9580;
            7'd18: v = 16'd10126;    7'd19: v = 16'd10668;    7'd20: v = 16'd11207;
            7'd21: v = 16'd11743;    7'd22: v = 16'd12275;    7'd23: v = 16'd12803;
            7'd24: v = 16'd13328;    7'd25: v = 16'd13848;    7'd26: v = 16'd14365;
            7'd27: v = 16'd14876;    7'd28: v = 16'd15384;    7'd29: v = 16'd15886;
            7'd30: v = 16'd16384;    7'd31: v = 16'd16877;    7'd32: v = 16'd17364;
            7'd33: v = 16'd17847;    7'd34: v = 16'd18324;    7'd35: v = 16'd18795;
            7'd36: v = 16'd19261;    7'd37: v = 16'd19720;    7'd38: v = 16'd20174;
            7'd39: v = 16'd20622;    7'd40: v = 16'd21063;    7'd41: v = 16'd21498;
            7'd42: v = 16'd21926;    7'd43: v = 16'd22348;    7'd44: v = 16'd22763;
            7'd45: v = 16'd23170;    7'd46: v = 16'd23571;    7'd47: v = 16'd23965;
            7'd48: v = 16'd24351;    7'd49: v = 16'd24730;    7'd50: v = 16'd25102;
            7'd51: v = 16'd25466;    7'd52: v = 16'd25822;    7'd53: v = 16'd26170;
            7'd54: v = 16'd26510;    7'd55: v = 16'd26842;    7'd56: v = 16'd27166;
            7'd57: v = 16'd27482;    7'd58: v = 16'd27789;    7'd59: v = 16'd28088;
            7'd60: v = 16'd28378;    7'd61: v = 16'd28660;    7'd62: v = 16'd28932;
            7'd63: v = 16'd29197;    7'd64: v = 16'd29452;    7'd65: v = 16'd29698;
            7'd66: v = 16'd29935;    7'd67: v = 16'd30163;    7'd68: v = 16'd30382;
            7'd69: v = 16'd30592;    7'd70: v = 16'd30792;    7'd71: v = 16'd30983;
            7'd72: v = 16'd31164;    7'd73: v = 16'd31336;    7'd74: v = 16'd31499;
            7'd75: v = 16'd31651;    7'd76: v = 16'd31795;    7'd77: v = 16'd31928;
            7'd78: v = 16'd32052;    7'd79: v = 16'd32166;    7'd80: v = 16'd32270;
            7'd81: v = 16'd32365;    7'd82: v = 16'd32449;    7'd83: v = 16'd32524;
            7'd84: v = 16'd32588;    7'd85: v = 16'd32643;    7'd86: v = 16'd32688;
            7'd87: v = 16'd32723;    7'd88: v = 16'd32748;    7'd89: v = 16'd32763;
            7'd90: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Signed sine for an angle in 0..359 degrees, folded onto the quarter table.
    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0]        fold;
        logic                    neg;
        logic signed [TRIG_W-1:0] mag;
        if (d <= 9'd90) begin
            fold = d;
            neg  = 1'b0;
        end else if (d <= 9'd180) begin
            fold = 9'd180 - d;
            neg  = 1'b0;
        end else if (d <= 9'd270) begin
            fold = d - 9'd180;
            neg  = 1'b1;
        end else begin
            fold = 9'd360 - d;
            neg  = 1'b1;
        end
        mag = $signed({1'b0, sin_q15(fold[6:0])});
        return neg ? -mag : mag;
    endfunction

endpackage

FILE: sv/iq_leakage_cancel_rotating_loop.sv
// Carrier leakage cancellation loop. Each input beat is either a start command or one
// I/Q ADC sample pair. A start loads all four DAC codes (Q+, Q-, I+, I-) with dac_center
// and sweeps the angles below 360 in steps of 360/ANGLE_STEPS. Per angle it applies
// iters_per_angle adjust samples, each of which rotates the common-mode-free error
// vector by the angle, scales it by 1/100 and steers the code pairs (saturating to
// 0..1023), followed by one measure sample that keeps the codes with the lowest
// I^2+Q^2. After the last angle the best codes are driven and phase reports finished.
// Every input beat produces exactly one output beat. The block takes one beat per
// clock cycle while the output is not stalled. The beat is registered with its angle
// lookup when it is accepted, then passes the rotation-multiply and reciprocal-divide
// registers, and the code update then loads the output register from the divide register.
// Output stalls back up through these four registers, so the input stalls only when
// all four hold beats and the receiver is stalling. Configuration is written through
// a separate valid/ready port that is always ready and should only be used while no
// beat is in flight.
module iq_leakage_cancel_rotating_loop
    import iqlc_pkg::*;
#(
    parameter int ANGLE_STEPS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_beat              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_beat             o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The angle step is an integer number of degrees; the sweep visits every
    // multiple of it below 360.
    localparam int STEP_INT  = 360 / ANGLE_STEPS;
    localparam int COUNT_INT = (360 + STEP_INT - 1) / STEP_INT;
    localparam logic [DEG_W-1:0]   STEP_DEG    = DEG_W'(STEP_INT);
    localparam logic [ANGLE_W:0]   ANGLE_COUNT = (ANGLE_W + 1)'(COUNT_INT);

    // Configuration registers.
    logic [CODE_W-1:0] r_center;
    logic [ADC_W-1:0]  r_cm;
    logic [ITER_W-1:0] r_iters;

    // Sweep control state, advanced as each beat is accepted.
    logic               r_running;
    logic [ITER_W-1:0]  r_iter;
    logic [ANGLE_W-1:0] r_angle_idx;
    logic [DEG_W-1:0]   r_angle_deg;
    logic               n_running;
    logic [ITER_W-1:0]  n_iter;
    logic [ANGLE_W-1:0] n_angle_idx;
    logic [DEG_W-1:0]   n_angle_deg;
    logic [2:0]         n_op;

    // Code state, updated as each result is written to the output register.
    logic [3:0][CODE_W-1:0] r_dac;
    logic [3:0][CODE_W-1:0] r_best;
    logic [PWR_W-1:0]       r_min_power;
    logic [3:0][CODE_W-1:0] n_dac;
    logic [3:0][CODE_W-1:0] n_best;
    logic [PWR_W-1:0]       n_min_power;
    logic [2:0]             n_phase;

    // Pipeline stage 1: offset-free samples and the trig values of the angle.
    logic                     r_v1;
    logic [2:0]               r_op1;
    logic signed [SAMP_W-1:0] r_q1;
    logic signed [SAMP_W-1:0] r_i1;
    logic signed [TRIG_W-1:0] r_sin1;
    logic signed [TRIG_W-1:0] r_cos1;

    // Stage 2: rotated numerators and the measured power.
    logic                    r_v2;
    logic [2:0]              r_op2;
    logic signed [NUM_W-1:0] r_num_i2;
    logic signed [NUM_W-1:0] r_num_q2;
    logic [PWR_W-1:0]        r_pwr2;

    // Stage 3: code steps after the divide by 100 * 32768.
    logic                      r_v3;
    logic [2:0]                r_op3;
    logic signed [DELTA_W-1:0] r_di3;
    logic signed [DELTA_W-1:0] r_dq3;
    logic [PWR_W-1:0]          r_pwr3;

    // Output register.
    logic      r_ov;
    t_out_beat r_out;

    // Per-stage flow control; a stage moves on when the next one is empty or moving.
    logic out_ready;
    logic ready3;
    logic ready2;
    logic ready1;
    logic in_take;
    logic load_out;

    assign out_ready = !r_ov || !i_stall;
    assign ready3    = !r_v3 || out_ready;
    assign ready2    = !r_v2 || ready3;
    assign ready1    = !r_v1 || ready2;
    assign o_stall   = !ready1;
    assign in_take   = i_valid && ready1;
    assign load_out  = r_v3 && out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= RST_DAC_CENTER;
            r_cm     <= RST_COMMON_MODE;
            r_iters  <= RST_ITERS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DAC_CENTER:  r_center <= i_cfg_data[CODE_W-1:0];
                CFG_COMMON_MODE: r_cm     <= i_cfg_data[ADC_W-1:0];
                CFG_ITERS:       r_iters  <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Decide what the incoming beat does from its action bit, the sweep counters and the
    // iteration setting; it is settled here and the datapath just follows it.
    always_comb begin
        n_running   = r_running;
        n_iter      = r_iter;
        n_angle_idx = r_angle_idx;
        n_angle_deg = r_angle_deg;
        n_op        = OP_IDLE;
        if (i_data.action) begin
            n_running   = 1'b1;
            n_iter      = '0;
            n_angle_idx = '0;
            n_angle_deg = '0;
            n_op        = OP_START;
        end else if (!r_running) begin
            n_op = OP_IDLE;
        end else if (r_iter < r_iters) begin
            n_iter = r_iter + 1'b1;
            n_op   = OP_ADJUST;
        end else begin
            n_iter = '0;
            if ({1'b0, r_angle_idx} + 1'b1 >= ANGLE_COUNT) begin
                n_running   = 1'b0;
                n_angle_idx = '0;
                n_angle_deg = '0;
                n_op        = OP_LAST;
            end else begin
                n_angle_idx = r_angle_idx + 1'b1;
                n_angle_deg = r_angle_deg + STEP_DEG;
                n_op        = OP_MEASURE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_iter      <= '0;
            r_angle_idx <= '0;
            r_angle_deg <= '0;
        end else if (in_take) begin
            r_running   <= n_running;
            r_iter      <= n_iter;
            r_angle_idx <= n_angle_idx;
            r_angle_deg <= n_angle_deg;
        end
    end

    // Stage 1 inputs: cosine is the sine of the angle plus 90 degrees.
    logic [DEG_W:0]   cos_sum;
    logic [DEG_W-1:0] cos_deg;

    assign cos_sum = {1'b0, r_angle_deg} + 10'd90;
    assign cos_deg = (cos_sum >= 10'd360) ? DEG_W'(cos_sum - 10'd360) : cos_sum[DEG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_op1  <= n_op;
            r_q1   <= $signed({1'b0, i_data.adc_q}) - $signed({1'b0, r_cm});
            r_i1   <= $signed({1'b0, i_data.adc_i}) - $signed({1'b0, r_cm});
            r_sin1 <= sin_deg(r_angle_deg);
            r_cos1 <= sin_deg(cos_deg);
        end
    end

    // Stage 2: rotation and power. Each product fits well inside NUM_W bits.
    logic signed [NUM_W-1:0]    prod_ic;
    logic signed [NUM_W-1:0]    prod_qs;
    logic signed [NUM_W-1:0]    prod_qc;
    logic signed [NUM_W-1:0]    prod_is;
    logic signed [2*SAMP_W-1:0] sq_q;
    logic signed [2*SAMP_W-1:0] sq_i;

    assign prod_ic = NUM_W'(r_i1) * NUM_W'(r_cos1);
    assign prod_qs = NUM_W'(r_q1) * NUM_W'(r_sin1);
    assign prod_qc = NUM_W'(r_q1) * NUM_W'(r_cos1);
    assign prod_is = NUM_W'(r_i1) * NUM_W'(r_sin1);
    assign sq_q    = r_q1 * r_q1;
    assign sq_i    = r_i1 * r_i1;

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_op2    <= r_op1;
            r_num_i2 <= prod_ic + prod_qs;
            r_num_q2 <= prod_qc - prod_is;
            r_pwr2   <= PWR_W'(sq_q) + PWR_W'(sq_i);
        end
    end

    // Stage 3: divide by 100 * 32768, truncating toward zero. The magnitude is
    // below 2^28, so after the shift an 11-bit value is divided by 25.
    function automatic logic signed [DELTA_W-1:0] div_step(
        input logic signed [NUM_W-1:0] num
    );
        logic [NUM_W-1:0] mag;
        logic [10:0]      hi;
        logic [22:0]      prod;
        logic [6:0]       quo;
        mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        hi   = mag[DIV_SHIFT+10:DIV_SHIFT];
        prod = 23'(hi) * 23'(RECIP_25);
        quo  = prod[RECIP_SH+6:RECIP_SH];
        return num[NUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    endfunction

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r_op3  <= r_op2;
            r_di3  <= div_step(r_num_i2);
            r_dq3  <= div_step(r_num_q2);
            r_pwr3 <= r_pwr2;
        end
    end

    // Step a code by a signed amount and clamp it to the DAC range.
    function automatic logic [CODE_W-1:0] step_code(
        input logic [CODE_W-1:0]         code,
        input logic signed [DELTA_W-1:0] d,
        input logic                      sub
    );
        logic signed [CODE_W+1:0] ext;
        logic signed [CODE_W+1:0] sum;
        ext = (CODE_W + 2)'(d);
        sum = $signed({2'b00, code}) + (sub ? -ext : ext);
        if (sum < 0) begin
            return '0;
        end else if (sum > $signed({2'b00, CODE_MAX})) begin
            return CODE_MAX;
        end else begin
            return sum[CODE_W-1:0];
        end
    endfunction

    // Final stage: code update and best-power tracking.
    always_comb begin
        n_dac       = r_dac;
        n_best      = r_best;
        n_min_power = r_min_power;
        n_phase     = PH_IDLE;
        case (r_op3)
            OP_START: begin
                n_dac       = {4{r_center}};
                n_best      = {4{r_center}};
                n_min_power = POWER_INIT;
                n_phase     = PH_STARTED;
            end
            OP_ADJUST: begin
                n_dac[0] = step_code(r_dac[0], r_dq3, 1'b0);
                n_dac[1] = step_code(r_dac[1], r_dq3, 1'b1);
                n_dac[2] = step_code(r_dac[2], r_di3, 1'b0);
                n_dac[3] = step_code(r_dac[3], r_di3, 1'b1);
                n_phase  = PH_ADJUSTED;
            end
            OP_MEASURE, OP_LAST: begin
                if (r_pwr3 < r_min_power) begin
                    n_min_power = r_pwr3;
                    n_best      = r_dac;
                end
                if (r_op3 == OP_LAST) begin
                    n_dac   = n_best;
                    n_phase = PH_FINISHED;
                end else begin
                    n_phase = PH_MEASURED;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac       <= '0;
            r_best      <= '0;
            r_min_power <= POWER_INIT;
        end else if (load_out) begin
            r_dac       <= n_dac;
            r_best      <= n_best;
            r_min_power <= n_min_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.dac_q_pos  <= n_dac[0];
            r_out.dac_q_neg  <= n_dac[1];
            r_out.dac_i_pos  <= n_dac[2];
            r_out.dac_i_neg  <= n_dac[3];
            r_out.phase      <= n_phase;
            r_out.best_power <= n_min_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= in_take;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (out_ready) begin
                r_ov <= r_v3;
            end
        end
    end

    // The angle counter and the degree accumulator stay in step and in range.
    a_angle_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_angle_idx} < ANGLE_COUNT) &&
        (32'(r_angle_deg) == 32'(r_angle_idx) * 32'(STEP_INT)))
        else $error("angle index and angle degrees disagree");

    // The best power only falls, except when a start reloads it.
    a_power_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_op3 != OP_START) |=> (r_min_power <= $past(r_min_power)))
        else $error("best power increased without a start");

    // At the end of a sweep the driven codes are the best codes.
    a_finish_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_op3 == OP_LAST) |=> (r_dac == r_best))
        else $error("finish did not load best codes");

    // Back-pressure reaches the input only when every stage is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_ov && i_stall))
        else $error("input stalled while the pipeline has room");

endmodule
